// File: rtl/text_console_cursor_controller_assert.svh
// Assertion macros shared by the text console cursor controller modules
`ifndef TEXT_CONSOLE_CURSOR_CONTROLLER_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_CONTROLLER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge out of reset
`define TCCC_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset
`define TCCC_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/tccc_pkg.sv
// Package: types, constants and helpers of the text console cursor controller
`timescale 1ns / 1ps

package tccc_pkg;

    // Glyph cell size and text grid limits
    localparam int GLYPH_W  = 8;
    localparam int GLYPH_H  = 16;
    localparam int MAX_COLS = 256;
    localparam int MAX_ROWS = 128;

    // Field widths
    localparam int MODE_W  = 3;
    localparam int CHAR_W  = 8;
    localparam int COLOR_W = 32;
    localparam int CMD_W   = 3;
    localparam int PIX_W   = 13;
    localparam int CFG_W   = 12;
    localparam int RECT_W  = 12;
    localparam int ROW_W   = 7;
    localparam int COL_W   = 9;
    localparam int ROWS_W  = 8;

    // Configuration port
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    // Command queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int PTR_W   = $clog2(Q_DEPTH);
    localparam int CNT_W   = $clog2(Q_DEPTH + 1);

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

    // Register reset values
    localparam logic [CFG_W-1:0]   AREA_W_RST = 12'd640;
    localparam logic [CFG_W-1:0]   AREA_H_RST = 12'd480;
    localparam logic [COLOR_W-1:0] INK_RST    = 32'hFFFF_FFFF;
    localparam logic [COLOR_W-1:0] PAPER_RST  = 32'h0000_0000;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUT   = 3'd0,
        MODE_BKSP  = 3'd1,
        MODE_CLEAR = 3'd2,
        MODE_SHOW  = 3'd3,
        MODE_HIDE  = 3'd4
    } t_mode;

    typedef enum logic [CMD_W-1:0] {
        CMD_GLYPH  = 3'd0,
        CMD_FILL   = 3'd1,
        CMD_SCROLL = 3'd2,
        CMD_CURSOR = 3'd3,
        CMD_ERASE  = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_AREA_W   = 3'd2,
        REG_AREA_H   = 3'd3,
        REG_INK      = 3'd4,
        REG_PAPER    = 3'd5
    } t_reg;

    // Kind of drawing operation queued by the front
    typedef enum logic [2:0] {
        OP_GLYPH,
        OP_CELL_FILL,
        OP_AREA_FILL,
        OP_SCROLL,
        OP_CURSOR,
        OP_ERASE
    } t_op_kind;

    typedef enum logic {
        PH_FIRST,
        PH_SECOND
    } t_bphase;

    typedef struct packed {
        t_op_kind         kind;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_op;

    // One classified input: one or two operations plus the cursor state after it
    typedef struct packed {
        logic               two;
        t_op                first;
        t_op                second;
        logic [CHAR_W-1:0]  glyph;
        logic [COLOR_W-1:0] fore;
        logic [ROW_W-1:0]   row_out;
        logic [COL_W-1:0]   col_out;
        logic               shown;
    } t_job;

    typedef struct packed {
        logic [CFG_W-1:0]   origin_x;
        logic [CFG_W-1:0]   origin_y;
        logic [CFG_W-1:0]   area_w;
        logic [CFG_W-1:0]   area_h;
        logic [COLOR_W-1:0] ink;
        logic [COLOR_W-1:0] paper;
        logic [COL_W-1:0]   cols;
        logic [ROWS_W-1:0]  rows;
    } t_cfg;

    // Column count of an area width, at least one, at most MAX_COLS
    function automatic logic [COL_W-1:0] col_count(input logic [CFG_W-1:0] w);
        logic [CFG_W-1:0] q;
        begin
            q = CFG_W'(w / GLYPH_W);
            if (q == '0) begin
                q = CFG_W'(1);
            end else if (q > CFG_W'(MAX_COLS)) begin
                q = CFG_W'(MAX_COLS);
            end
            return COL_W'(q);
        end
    endfunction

    // Row count of an area height, at least one, at most MAX_ROWS
    function automatic logic [ROWS_W-1:0] row_count(input logic [CFG_W-1:0] h);
        logic [CFG_W-1:0] q;
        begin
            q = CFG_W'(h / GLYPH_H);
            if (q == '0) begin
                q = CFG_W'(1);
            end else if (q > CFG_W'(MAX_ROWS)) begin
                q = CFG_W'(MAX_ROWS);
            end
            return ROWS_W'(q);
        end
    endfunction

endpackage

// File: rtl/tccc_in_if.sv
// Interface: console command channel
`timescale 1ns / 1ps

interface tccc_in_if;
    import tccc_pkg::*;

    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [CHAR_W-1:0]  char_code;
    logic               use_alt_color;
    logic [COLOR_W-1:0] alt_color;

    modport source (
        output valid, mode, char_code, use_alt_color, alt_color,
        input  ready
    );

    modport sink (
        input  valid, mode, char_code, use_alt_color, alt_color,
        output ready
    );
endinterface

// File: rtl/tccc_out_if.sv
// Interface: drawing command channel
`timescale 1ns / 1ps

interface tccc_out_if;
    import tccc_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [PIX_W-1:0]   pixel_x;
    logic [PIX_W-1:0]   pixel_y;
    logic [RECT_W-1:0]  rect_w;
    logic [RECT_W-1:0]  rect_h;
    logic [CHAR_W-1:0]  glyph;
    logic [COLOR_W-1:0] fore_color;
    logic [COLOR_W-1:0] back_color;
    logic               last;
    logic [ROW_W-1:0]   cursor_row_out;
    logic [COL_W-1:0]   cursor_col_out;
    logic               cursor_shown;

    modport source (
        output valid, command, pixel_x, pixel_y, rect_w, rect_h, glyph,
               fore_color, back_color, last, cursor_row_out, cursor_col_out,
               cursor_shown,
        input  ready
    );

    modport sink (
        input  valid, command, pixel_x, pixel_y, rect_w, rect_h, glyph,
               fore_color, back_color, last, cursor_row_out, cursor_col_out,
               cursor_shown,
        output ready
    );
endinterface

// File: rtl/tccc_regs.sv
// Configuration registers behind the APB-style port, with derived grid size
`timescale 1ns / 1ps

module tccc_regs (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [tccc_pkg::ADDR_W-1:0] paddr,
    input  logic [tccc_pkg::DATA_W-1:0] pwdata,
    output logic [tccc_pkg::DATA_W-1:0] prdata,
    output logic                   pready,
    output tccc_pkg::t_cfg         o_cfg
);
    import tccc_pkg::*;

    t_cfg r_cfg;
    t_reg w_idx;
    logic w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg'(paddr[ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    // Write registers; refresh column and row counts with the area size
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x <= '0;
            r_cfg.origin_y <= '0;
            r_cfg.area_w   <= AREA_W_RST;
            r_cfg.area_h   <= AREA_H_RST;
            r_cfg.ink      <= INK_RST;
            r_cfg.paper    <= PAPER_RST;
            r_cfg.cols     <= col_count(AREA_W_RST);
            r_cfg.rows     <= row_count(AREA_H_RST);
        end else if (w_wr) begin
            unique case (w_idx)
                REG_ORIGIN_X: r_cfg.origin_x <= pwdata[CFG_W-1:0];
                REG_ORIGIN_Y: r_cfg.origin_y <= pwdata[CFG_W-1:0];
                REG_AREA_W: begin
                    r_cfg.area_w <= pwdata[CFG_W-1:0];
                    r_cfg.cols   <= col_count(pwdata[CFG_W-1:0]);
                end
                REG_AREA_H: begin
                    r_cfg.area_h <= pwdata[CFG_W-1:0];
                    r_cfg.rows   <= row_count(pwdata[CFG_W-1:0]);
                end
                REG_INK:   r_cfg.ink   <= pwdata;
                REG_PAPER: r_cfg.paper <= pwdata;
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        unique case (w_idx)
            REG_ORIGIN_X: prdata = DATA_W'(r_cfg.origin_x);
            REG_ORIGIN_Y: prdata = DATA_W'(r_cfg.origin_y);
            REG_AREA_W:   prdata = DATA_W'(r_cfg.area_w);
            REG_AREA_H:   prdata = DATA_W'(r_cfg.area_h);
            REG_INK:      prdata = r_cfg.ink;
            REG_PAPER:    prdata = r_cfg.paper;
            default:      prdata = '0;
        endcase
    end

endmodule

// File: rtl/tccc_front.sv
// Front end: accepts console commands, updates the cursor and classifies the work
`timescale 1ns / 1ps

module tccc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    tccc_in_if.sink        i_cmd,
    input  tccc_pkg::t_cfg i_cfg,
    input  logic           i_q_full,
    output logic           o_push,
    output tccc_pkg::t_job o_job
);
    import tccc_pkg::*;

    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_col, n_col;
    logic             r_shown, n_shown;

    logic [ROW_W-1:0] w_row_c;
    logic [COL_W-1:0] w_col_c;
    logic             w_last_row;
    logic [ROW_W-1:0] w_g_row;
    logic [COL_W-1:0] w_g_col;
    logic             w_scroll;
    logic             w_has;
    logic             w_acc;
    t_job             w_job;

    assign i_cmd.ready = !i_q_full;
    assign w_acc       = i_cmd.valid && i_cmd.ready;
    assign o_push      = w_acc && w_has;
    assign o_job       = w_job;

    // Pull the cursor back inside a shrunk area
    always_comb begin
        w_row_c    = (ROWS_W'(r_row) >= i_cfg.rows) ? ROW_W'(i_cfg.rows - ROWS_W'(1)) : r_row;
        w_col_c    = (r_col > i_cfg.cols) ? i_cfg.cols : r_col;
        w_last_row = (ROWS_W'(w_row_c) == i_cfg.rows - ROWS_W'(1));
    end

    // Cell for a printable glyph, after any pending wrap
    always_comb begin
        w_g_row  = w_row_c;
        w_g_col  = w_col_c;
        w_scroll = 1'b0;
        if (w_col_c >= i_cfg.cols) begin
            w_g_col = '0;
            if (w_last_row) begin
                w_scroll = 1'b1;
            end else begin
                w_g_row = w_row_c + ROW_W'(1);
            end
        end
    end

    // Classify the command: operations to draw and the cursor state after it
    always_comb begin
        n_row   = w_row_c;
        n_col   = w_col_c;
        n_shown = r_shown;
        w_has   = 1'b0;
        w_job   = '0;
        unique case (t_mode'(i_cmd.mode))
            MODE_PUT: begin
                if (i_cmd.char_code == NEWLINE_CODE) begin
                    n_col = '0;
                    if (w_last_row) begin
                        w_has       = 1'b1;
                        w_job.first = '{kind: OP_SCROLL, row: '0, col: '0};
                    end else begin
                        n_row = w_row_c + ROW_W'(1);
                    end
                end else begin
                    w_has = 1'b1;
                    n_row = w_g_row;
                    n_col = w_g_col + COL_W'(1);
                    if (w_scroll) begin
                        w_job.two    = 1'b1;
                        w_job.first  = '{kind: OP_SCROLL, row: '0, col: '0};
                        w_job.second = '{kind: OP_GLYPH, row: w_g_row, col: w_g_col};
                    end else begin
                        w_job.first  = '{kind: OP_GLYPH, row: w_g_row, col: w_g_col};
                    end
                    w_job.glyph = i_cmd.char_code;
                    w_job.fore  = i_cmd.use_alt_color ? i_cmd.alt_color : i_cfg.ink;
                end
            end
            MODE_BKSP: begin
                w_has       = 1'b1;
                n_shown     = 1'b0;
                w_job.first = '{kind: OP_ERASE, row: w_row_c, col: w_col_c};
                if (w_col_c != '0) begin
                    n_col        = w_col_c - COL_W'(1);
                    w_job.two    = 1'b1;
                    w_job.second = '{kind: OP_CELL_FILL, row: w_row_c, col: n_col};
                end else if (w_row_c != '0) begin
                    n_row        = w_row_c - ROW_W'(1);
                    n_col        = i_cfg.cols - COL_W'(1);
                    w_job.two    = 1'b1;
                    w_job.second = '{kind: OP_CELL_FILL, row: n_row, col: n_col};
                end
            end
            MODE_CLEAR: begin
                w_has       = 1'b1;
                n_row       = '0;
                n_col       = '0;
                w_job.first = '{kind: OP_AREA_FILL, row: '0, col: '0};
            end
            MODE_SHOW: begin
                w_has       = 1'b1;
                n_shown     = 1'b1;
                w_job.first = '{kind: OP_CURSOR, row: w_row_c, col: w_col_c};
            end
            MODE_HIDE: begin
                w_has       = 1'b1;
                n_shown     = 1'b0;
                w_job.first = '{kind: OP_ERASE, row: w_row_c, col: w_col_c};
            end
            default: ;
        endcase
        w_job.row_out = n_row;
        w_job.col_out = n_col;
        w_job.shown   = n_shown;
    end

    // Commit the cursor state on every accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row   <= '0;
            r_col   <= '0;
            r_shown <= 1'b0;
        end else if (w_acc) begin
            r_row   <= n_row;
            r_col   <= n_col;
            r_shown <= n_shown;
        end
    end

endmodule

// File: rtl/tccc_queue.sv
// Short job queue between the front and back ends
`timescale 1ns / 1ps
`include "text_console_cursor_controller_assert.svh"

module tccc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tccc_pkg::t_job i_data,
    input  logic           i_pop,
    output tccc_pkg::t_job o_data,
    output logic           o_valid,
    output logic           o_full
);
    import tccc_pkg::*;

    t_job             r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_data  = r_mem[r_rd_ptr];
    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CNT_W'(Q_DEPTH));

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the pushed job
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `TCCC_ASSERT_IMP(a_q_no_overflow, i_clk, i_rst_n, i_push, r_count != CNT_W'(Q_DEPTH), "push into a full job queue")
    `TCCC_ASSERT_IMP(a_q_no_underflow, i_clk, i_rst_n, i_pop, r_count != '0, "pop from an empty job queue")

endmodule

// File: rtl/tccc_back.sv
// Back end: expands queued jobs into drawing beats through an output register
`timescale 1ns / 1ps
`include "text_console_cursor_controller_assert.svh"

module tccc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tccc_pkg::t_cfg i_cfg,
    input  logic           i_q_valid,
    input  tccc_pkg::t_job i_job,
    output logic           o_pop,
    tccc_out_if.source     o_draw
);
    import tccc_pkg::*;

    t_bphase r_phase, n_phase;

    logic               r_valid;
    t_cmd               r_cmd, n_cmd;
    logic [PIX_W-1:0]   r_x, n_x;
    logic [PIX_W-1:0]   r_y, n_y;
    logic [RECT_W-1:0]  r_w, n_w;
    logic [RECT_W-1:0]  r_h, n_h;
    logic [CHAR_W-1:0]  r_glyph, n_glyph;
    logic [COLOR_W-1:0] r_fore, n_fore;
    logic [COLOR_W-1:0] r_back, n_back;
    logic               r_last;
    logic [ROW_W-1:0]   r_row;
    logic [COL_W-1:0]   r_col;
    logic               r_shown;

    t_op              w_op;
    logic             w_last;
    logic             w_load;
    logic             w_take;
    logic [PIX_W-1:0] w_cell_x;
    logic [PIX_W-1:0] w_cell_y;

    assign w_load = !r_valid || o_draw.ready;
    assign w_take = w_load && i_q_valid;
    assign w_op   = (r_phase == PH_SECOND) ? i_job.second : i_job.first;
    assign w_last = !i_job.two || (r_phase == PH_SECOND);

    // Pixel corner of the operation's cell
    assign w_cell_x = PIX_W'(i_cfg.origin_x) + PIX_W'(w_op.col) * PIX_W'(GLYPH_W);
    assign w_cell_y = PIX_W'(i_cfg.origin_y) + PIX_W'(w_op.row) * PIX_W'(GLYPH_H);

    // Step to the second operation of a two-beat job
    always_comb begin
        n_phase = r_phase;
        if (w_take) begin
            n_phase = w_last ? PH_FIRST : PH_SECOND;
        end
    end

    // Build the next beat and release the job on its final beat
    always_comb begin
        o_pop   = w_take && w_last;
        n_cmd   = CMD_GLYPH;
        n_x     = w_cell_x;
        n_y     = w_cell_y;
        n_w     = '0;
        n_h     = '0;
        n_glyph = '0;
        n_fore  = '0;
        n_back  = i_cfg.paper;
        unique case (w_op.kind)
            OP_GLYPH: begin
                n_cmd   = CMD_GLYPH;
                n_glyph = i_job.glyph;
                n_fore  = i_job.fore;
            end
            OP_CELL_FILL: begin
                n_cmd = CMD_FILL;
                n_w   = RECT_W'(GLYPH_W);
                n_h   = RECT_W'(GLYPH_H);
            end
            OP_AREA_FILL: begin
                n_cmd = CMD_FILL;
                n_x   = PIX_W'(i_cfg.origin_x);
                n_y   = PIX_W'(i_cfg.origin_y);
                n_w   = i_cfg.area_w;
                n_h   = i_cfg.area_h;
            end
            OP_SCROLL: begin
                n_cmd = CMD_SCROLL;
                n_x   = PIX_W'(i_cfg.origin_x);
                n_y   = PIX_W'(i_cfg.origin_y);
                n_w   = i_cfg.area_w;
                n_h   = i_cfg.area_h;
            end
            OP_CURSOR: begin
                n_cmd  = CMD_CURSOR;
                n_fore = i_cfg.ink;
                n_back = '0;
            end
            OP_ERASE: begin
                n_cmd = CMD_ERASE;
            end
            default: ;
        endcase
    end

    // Control: output valid and phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= PH_FIRST;
        end else begin
            r_phase <= n_phase;
            if (w_load) begin
                r_valid <= i_q_valid;
            end
        end
    end

    // Output beat register; hold while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_cmd   <= n_cmd;
            r_x     <= n_x;
            r_y     <= n_y;
            r_w     <= n_w;
            r_h     <= n_h;
            r_glyph <= n_glyph;
            r_fore  <= n_fore;
            r_back  <= n_back;
            r_last  <= w_last;
            r_row   <= i_job.row_out;
            r_col   <= i_job.col_out;
            r_shown <= i_job.shown;
        end
    end

    assign o_draw.valid          = r_valid;
    assign o_draw.command        = r_cmd;
    assign o_draw.pixel_x        = r_x;
    assign o_draw.pixel_y        = r_y;
    assign o_draw.rect_w         = r_w;
    assign o_draw.rect_h         = r_h;
    assign o_draw.glyph          = r_glyph;
    assign o_draw.fore_color     = r_fore;
    assign o_draw.back_color     = r_back;
    assign o_draw.last           = r_last;
    assign o_draw.cursor_row_out = r_row;
    assign o_draw.cursor_col_out = r_col;
    assign o_draw.cursor_shown   = r_shown;

    `TCCC_ASSERT_IMP(a_second_has_job, i_clk, i_rst_n, r_phase == PH_SECOND, i_q_valid && i_job.two, "second beat pending without a two-beat job")
    `TCCC_ASSERT_IMP(a_mid_beat_phase, i_clk, i_rst_n, r_valid && !r_last, r_phase == PH_SECOND, "non-final beat shown without its successor pending")

endmodule

// File: rtl/text_console_cursor_controller.sv
// Top level: text console cursor controller
`timescale 1ns / 1ps
// Text console cursor controller.
// i_cmd carries console commands (put character, backspace, clear, show and
// hide cursor); o_draw carries drawing beats (glyph, fill, scroll, cursor
// draw and erase), one to two per command, the final one flagged by last.
// Every beat carries the cursor row, column and shown flag after its command.
// Newline without scroll and unknown modes give no beat.
// Configuration goes through the APB-style port; write it only while idle.
// The first beat of a command passes through the job queue and then the back
// end's output register before it is shown. Throughput: one drawing beat per
// cycle out of the back end while the receiver does not stall; a one-beat
// command is taken every cycle, a two-beat job leaves the queue on its last beat.
// A two-entry job queue sits between front and back, so commands keep being
// accepted while the receiver stalls until that queue fills; then ready falls.
// Reset (synchronous, active low) homes and hides the cursor, empties the
// queue and restores the registers to their default values.
module text_console_cursor_controller (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    tccc_in_if.sink                     i_cmd,
    tccc_out_if.source                  o_draw,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tccc_pkg::ADDR_W-1:0] paddr,
    input  logic [tccc_pkg::DATA_W-1:0] pwdata,
    output logic [tccc_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import tccc_pkg::*;

    t_cfg w_cfg;
    t_job w_push_job;
    t_job w_head_job;
    logic w_push;
    logic w_pop;
    logic w_q_valid;
    logic w_q_full;

    tccc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    tccc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (i_cmd),
        .i_cfg    (w_cfg),
        .i_q_full (w_q_full),
        .o_push   (w_push),
        .o_job    (w_push_job)
    );

    tccc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_job),
        .i_pop   (w_pop),
        .o_data  (w_head_job),
        .o_valid (w_q_valid),
        .o_full  (w_q_full)
    );

    tccc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_q_valid (w_q_valid),
        .i_job     (w_head_job),
        .o_pop     (w_pop),
        .o_draw    (o_draw)
    );

endmodule
